// ----- sv/unified_cordic_rotator_assert.svh -----
`ifndef UNIFIED_CORDIC_ROTATOR_ASSERT_SVH
`define UNIFIED_CORDIC_ROTATOR_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define UCR_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ucr assertion failed");

// Next-cycle implication, ignored while reset is high.
`define UCR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ucr assertion failed");

// Condition that must hold in the cycle after reset.
`define UCR_ASSERT_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("ucr reset assertion failed");

`endif

// ----- sv/ucr_pkg.sv -----
package ucr_pkg;

   localparam int STAGES_DEF    = 24;
   localparam int RANGE_EXP_DEF = 2;
   localparam int DATA_W        = 24;
   localparam int ACC_W         = 40;

   localparam int REP_A = 4;
   localparam int REP_B = 13;
   localparam int REP_C = 40;
   localparam int REP_D = 121;

   localparam logic signed [ACC_W-1:0] Q_HALF_PI       = ACC_W'(1647099);
   localparam logic signed [ACC_W-1:0] Q_PI            = ACC_W'(3294199);
   localparam logic signed [ACC_W-1:0] Q_THREE_HALF_PI = ACC_W'(4941298);
   localparam logic signed [ACC_W-1:0] Q_TWO_PI        = ACC_W'(6588397);
   localparam logic signed [ACC_W-1:0] SAT_HI          = ACC_W'(8388607);
   localparam logic signed [ACC_W-1:0] SAT_LO          = -ACC_W'(8388608);

   localparam int ATAN_HEAD[7]  = '{823550, 486170, 256879, 130396, 65451, 32757, 16383};
   localparam int ATANH_HEAD[7] = '{0, 575989, 267820, 131761, 65622, 32779, 16385};
   localparam int EXPAND_TAB[9] = '{1020217, 1419798, 1800398, 2172196, 2539749,
                                    2905218, 3269654, 3633575, 3997240};

   typedef enum logic [2:0] {
      CMD_CIRC_ROT = 3'd0,
      CMD_CIRC_VEC = 3'd1,
      CMD_LIN_ROT  = 3'd2,
      CMD_LIN_VEC  = 3'd3,
      CMD_HYP_ROT  = 3'd4,
      CMD_HYP_VEC  = 3'd5
   } cmd_type;

   typedef struct packed {
      logic                    valid;
      logic [2:0]              cmd;
      logic signed [ACC_W-1:0] x;
      logic signed [ACC_W-1:0] y;
      logic signed [ACC_W-1:0] z;
   } lane_type;

   function automatic int pow2_q20(int i);
      if (i <= 20) return 1 << (20 - i);
      return 0;
   endfunction

   function automatic int atan_const(int i);
      if (i < 7) return ATAN_HEAD[i];
      return pow2_q20(i);
   endfunction

   function automatic bit is_repeated(int j);
      return j == REP_A || j == REP_B || j == REP_C || j == REP_D;
   endfunction

   // Hyperbolic iteration index handled by cell k; stages-1 means the cell is idle.
   function automatic int hyp_index(int k, int stages, int rexp);
      int j;
      int n;
      int p;
      n = 0;
      for (j = -rexp; j <= stages - 2; j++) begin
         p = (j > 0 && is_repeated(j)) ? 2 : 1;
         if (k < n + p) return j;
         n = n + p;
      end
      return stages - 1;
   endfunction

   function automatic int cell_count(int stages, int rexp);
      int j;
      int n;
      n = rexp + 1;
      for (j = 1; j <= stages - 2; j++) n = n + (is_repeated(j) ? 2 : 1);
      if (n < stages - 1) n = stages - 1;
      return n;
   endfunction

   function automatic int artanh_const(int j);
      int e;
      e = -j;
      if (j <= 0) begin
         if (e > 8) e = 8;
         return EXPAND_TAB[e];
      end
      if (j < 7) return ATANH_HEAD[j];
      if (j == 21) return 1;
      return pow2_q20(j);
   endfunction

endpackage

// ----- sv/ucr_if.sv -----
interface ucr_req_if import ucr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [2:0]               cmd;
   logic signed [DATA_W-1:0] x_start;
   logic signed [DATA_W-1:0] y_start;
   logic signed [DATA_W-1:0] z_start;
   modport source (output valid, cmd, x_start, y_start, z_start, input ready);
   modport sink   (input valid, cmd, x_start, y_start, z_start, output ready);
endinterface

interface ucr_rsp_if import ucr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] x_result;
   logic signed [DATA_W-1:0] y_result;
   logic signed [DATA_W-1:0] z_result;
   logic                     overflow;
   modport source (output valid, x_result, y_result, z_result, overflow, input ready);
   modport sink   (input valid, x_result, y_result, z_result, overflow, output ready);
endinterface

// ----- sv/ucr_fold.sv -----
module ucr_fold import ucr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     valid,
   input  logic [2:0]               cmd,
   input  logic signed [DATA_W-1:0] x_start,
   input  logic signed [DATA_W-1:0] y_start,
   input  logic signed [DATA_W-1:0] z_start,
   output lane_type                 lane_out
);

   lane_type                stage_in;
   lane_type                stage_ff;
   logic signed [ACC_W-1:0] xs, ys, zs;

   always_comb begin
      xs = ACC_W'(x_start);
      ys = ACC_W'(y_start);
      zs = ACC_W'(z_start);
      stage_in.valid = valid;
      stage_in.cmd   = cmd;
      stage_in.x     = xs;
      stage_in.y     = ys;
      stage_in.z     = zs;
      unique case (cmd)
         CMD_CIRC_ROT: begin
            // fold angles in [-pi/2, 5pi/2] into [-pi/2, pi/2]
            if (zs > Q_HALF_PI && zs < Q_THREE_HALF_PI) begin
               stage_in.x = -xs;
               stage_in.y = -ys;
               stage_in.z = zs - Q_PI;
            end else if (zs >= Q_THREE_HALF_PI) begin
               stage_in.z = zs - Q_TWO_PI;
            end
         end
         CMD_CIRC_VEC: begin
            // pre-rotate left half plane by a quarter turn
            if (xs < 0) begin
               if (ys < 0) begin
                  stage_in.x = -ys;
                  stage_in.y = xs;
                  stage_in.z = zs - Q_HALF_PI;
               end else begin
                  stage_in.x = ys;
                  stage_in.y = -xs;
                  stage_in.z = zs + Q_HALF_PI;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign lane_out = stage_ff;

endmodule

// ----- sv/ucr_cell.sv -----
module ucr_cell import ucr_pkg::*; #(
   parameter int K               = 0,
   parameter int STAGES          = STAGES_DEF,
   parameter int RANGE_EXPANSION = RANGE_EXP_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     enable,
   input  lane_type lane_in,
   output lane_type lane_out
);

   localparam bit CIRC_EN = K <= STAGES - 2;
   localparam int HJ      = hyp_index(K, STAGES, RANGE_EXPANSION);
   localparam bit HYP_EN  = HJ <= STAGES - 2;
   localparam bit HYP_EXP = HJ <= 0;
   localparam int HYP_SH  = HYP_EXP ? 2 - HJ : HJ;
   localparam logic signed [ACC_W-1:0] ATAN_C  = ACC_W'(atan_const(K));
   localparam logic signed [ACC_W-1:0] LIN_C   = ACC_W'(pow2_q20(K));
   localparam logic signed [ACC_W-1:0] ATANH_C = ACC_W'(artanh_const(HJ));

   lane_type                stage_in;
   lane_type                stage_ff;
   logic signed [ACC_W-1:0] cx, cy, hx, hy;
   logic                    up;

   always_comb begin
      cx = lane_in.x >>> K;
      cy = lane_in.y >>> K;
      hx = HYP_EXP ? lane_in.x - (lane_in.x >>> HYP_SH) : lane_in.x >>> HYP_SH;
      hy = HYP_EXP ? lane_in.y - (lane_in.y >>> HYP_SH) : lane_in.y >>> HYP_SH;
      stage_in = lane_in;
      up = 1'b0;
      unique case (lane_in.cmd)
         CMD_CIRC_ROT, CMD_CIRC_VEC: begin
            up = lane_in.cmd[0] ? lane_in.y < 0 : lane_in.z >= 0;
            if (CIRC_EN) begin
               stage_in.x = up ? lane_in.x - cy : lane_in.x + cy;
               stage_in.y = up ? lane_in.y + cx : lane_in.y - cx;
               stage_in.z = up ? lane_in.z - ATAN_C : lane_in.z + ATAN_C;
            end
         end
         CMD_LIN_ROT, CMD_LIN_VEC: begin
            up = lane_in.cmd[0] ? lane_in.y < 0 : lane_in.z >= 0;
            if (CIRC_EN) begin
               stage_in.y = up ? lane_in.y + cx : lane_in.y - cx;
               stage_in.z = up ? lane_in.z - LIN_C : lane_in.z + LIN_C;
            end
         end
         CMD_HYP_ROT, CMD_HYP_VEC: begin
            up = lane_in.cmd[0]
               ? (lane_in.x != 0 && lane_in.y != 0 &&
                  lane_in.x[ACC_W-1] != lane_in.y[ACC_W-1])
               : lane_in.z >= 0;
            if (HYP_EN) begin
               stage_in.x = up ? lane_in.x + hy : lane_in.x - hy;
               stage_in.y = up ? lane_in.y + hx : lane_in.y - hx;
               stage_in.z = up ? lane_in.z - ATANH_C : lane_in.z + ATANH_C;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign lane_out = stage_ff;

endmodule

// ----- sv/unified_cordic_rotator.sv -----
// Unified CORDIC rotator: circular, linear and hyperbolic shift-add engine.
// req_chan carries cmd (0 circ rot, 1 circ vec, 2 lin rot, 3 lin vec,
// 4 hyp rot, 5 hyp vec; 6 and 7 pass the start values through) and x, y, z
// in signed Q3.20. rsp_chan returns x, y, z saturated to 24 bits and an
// overflow flag set when any of the three was clipped.
// Datapath: one fold cell (angle/half-plane reduction), a row of iteration
// cells, one per CORDIC step including hyperbolic range
// expansion and repeated steps, then a saturating output register.
// A transaction passes the fold register, the iteration cells (27 with
// STAGES = 24 and RANGE_EXPANSION = 2) and the output register. A new
// transaction is taken in every cycle that the row is not held; the row
// length is set by the hyperbolic schedule. While the receiver stalls with
// a result waiting, the whole row holds and req_chan.ready is low; the row
// advances again in the cycle the waiting result is taken.
// Reset is synchronous and clears all valid bits; the constant tables are
// elaborated into the cells, so no initialization pass is needed.
module unified_cordic_rotator import ucr_pkg::*; #(
   parameter int STAGES          = STAGES_DEF,
   parameter int RANGE_EXPANSION = RANGE_EXP_DEF
) (
   input logic    clock,
   input logic    reset,
   ucr_req_if.sink   req_chan,
   ucr_rsp_if.source rsp_chan
);

   `include "unified_cordic_rotator_assert.svh"

   localparam int NCELL = cell_count(STAGES, RANGE_EXPANSION);

   lane_type                 lane [NCELL+1];
   logic [NCELL:0]           pipe_valid;
   logic                     enable;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] x_ff, y_ff, z_ff;
   logic signed [DATA_W-1:0] x_in, y_in, z_in;
   logic                     ovf_ff, ovf_in;
   logic                     ox, oy, oz;
   logic                     rail_hit;

   assign enable         = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = enable;

   ucr_fold u_fold (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .valid    (req_chan.valid),
      .cmd      (req_chan.cmd),
      .x_start  (req_chan.x_start),
      .y_start  (req_chan.y_start),
      .z_start  (req_chan.z_start),
      .lane_out (lane[0])
   );

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      ucr_cell #(
         .K               (k),
         .STAGES          (STAGES),
         .RANGE_EXPANSION (RANGE_EXPANSION)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .lane_in  (lane[k]),
         .lane_out (lane[k+1])
      );
   end

   for (genvar k = 0; k <= NCELL; k++) begin : g_valid
      assign pipe_valid[k] = lane[k].valid;
   end

   function automatic logic signed [DATA_W-1:0] sat24(
      input logic signed [ACC_W-1:0] v, output logic clip);
      clip = 1'b1;
      if (v > SAT_HI) return DATA_W'(SAT_HI);
      if (v < SAT_LO) return DATA_W'(SAT_LO);
      clip = 1'b0;
      return v[DATA_W-1:0];
   endfunction

   always_comb begin
      x_in   = sat24(lane[NCELL].x, ox);
      y_in   = sat24(lane[NCELL].y, oy);
      z_in   = sat24(lane[NCELL].z, oz);
      ovf_in = ox | oy | oz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= lane[NCELL].valid;
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
         ovf_ff       <= ovf_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.x_result = x_ff;
   assign rsp_chan.y_result = y_ff;
   assign rsp_chan.z_result = z_ff;
   assign rsp_chan.overflow = ovf_ff;

   assign rail_hit = x_ff == DATA_W'(SAT_HI) || x_ff == DATA_W'(SAT_LO) ||
                     y_ff == DATA_W'(SAT_HI) || y_ff == DATA_W'(SAT_LO) ||
                     z_ff == DATA_W'(SAT_HI) || z_ff == DATA_W'(SAT_LO);

   `UCR_ASSERT_IMPL(a_ovf_clipped, rsp_valid_ff && ovf_ff, rail_hit)
   `UCR_ASSERT_NEXT(a_stall_holds_row, rsp_valid_ff && !rsp_chan.ready, $stable(pipe_valid) && rsp_valid_ff)
   `UCR_ASSERT_RESET(a_reset_empty, pipe_valid == '0 && !rsp_valid_ff)

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import ucr_pkg::*;

   typedef struct {
      logic [2:0]               cmd;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
   } cordic_in_type;

   typedef struct {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
      logic                     ovf;
   } cordic_out_type;

   typedef struct {
      cordic_in_type  stim;
      bit             known;
      cordic_out_type res;
   } row_type;

   localparam int NSTAGE = STAGES_DEF;
   localparam int REXP   = RANGE_EXP_DEF;
   localparam int LATENCY_WAIT = 64;
   localparam int RANDOM_ITEMS = 400;
   localparam logic signed [DATA_W-1:0] DMAX = 24'sh7FFFFF;
   localparam logic signed [DATA_W-1:0] DMIN = 24'sh800000;

   logic clock;
   logic reset;

   ucr_req_if req_chan ();
   ucr_rsp_if rsp_chan ();

   unified_cordic_rotator dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   cordic_out_type expected_results[$];
   row_type        rows[$];
   int             error_count;
   int             result_count;
   int             sent_count;
   int             cmd_hits[8];

   int atan_tab[NSTAGE];
   int lin_tab[NSTAGE];
   int atanh_tab[REXP + NSTAGE];

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int pw2(int i);
      if (i <= 20) return 1 << (20 - i);
      return 0;
   endfunction

   // Constant tables, built from the shift-add definitions.
   initial begin
      int heads_atan[7];
      int heads_atanh[7];
      int grow[9];
      int k;
      int j;
      int e;
      heads_atan  = '{823550, 486170, 256879, 130396, 65451, 32757, 16383};
      heads_atanh = '{0, 575989, 267820, 131761, 65622, 32779, 16385};
      grow = '{1020217, 1419798, 1800398, 2172196, 2539749, 2905218, 3269654, 3633575,
               3997240};
      for (k = 0; k < NSTAGE; k++) begin
         atan_tab[k] = (k < 7) ? heads_atan[k] : pw2(k);
         lin_tab[k]  = pw2(k);
      end
      for (k = 0; k < REXP + NSTAGE; k++) begin
         j = k - REXP;
         if (j <= 0) begin
            e = -j;
            atanh_tab[k] = grow[e > 8 ? 8 : e];
         end else if (j < 7) begin
            atanh_tab[k] = heads_atanh[j];
         end else if (j == 21) begin
            atanh_tab[k] = 1;
         end else begin
            atanh_tab[k] = pw2(j);
         end
      end
   end

   function automatic longint clip24(longint v, ref bit ovf);
      if (v > 64'sd8388607) begin
         ovf = 1'b1;
         return 64'sd8388607;
      end
      if (v < -64'sd8388608) begin
         ovf = 1'b1;
         return -64'sd8388608;
      end
      return v;
   endfunction

   function automatic cordic_out_type cordic_predict(cordic_in_type s);
      cordic_out_type r;
      longint x, y, z, tx, ty, t;
      bit vec, up, ovf;
      int i, j, p, passes;
      vec = s.cmd[0];
      x = s.x;
      y = s.y;
      z = s.z;
      ovf = 1'b0;
      if (s.cmd == CMD_CIRC_ROT || s.cmd == CMD_CIRC_VEC) begin
         if (!vec) begin
            if (z > 1647099 && z < 4941298) begin
               x = -x;
               y = -y;
               z -= 3294199;
            end else if (z >= 4941298) begin
               z -= 6588397;
            end
         end else if (x < 0) begin
            t = x;
            if (y < 0) begin
               x = -y;
               y = t;
               z -= 1647099;
            end else begin
               x = y;
               y = -t;
               z += 1647099;
            end
         end
         for (i = 0; i <= NSTAGE - 2; i++) begin
            up = vec ? (y < 0) : (z >= 0);
            tx = x >>> i;
            ty = y >>> i;
            if (up) begin
               x -= ty;
               y += tx;
               z -= atan_tab[i];
            end else begin
               x += ty;
               y -= tx;
               z += atan_tab[i];
            end
         end
      end else if (s.cmd == CMD_LIN_ROT || s.cmd == CMD_LIN_VEC) begin
         for (i = 0; i <= NSTAGE - 2; i++) begin
            up = vec ? (y < 0) : (z >= 0);
            tx = x >>> i;
            if (up) begin
               y += tx;
               z -= lin_tab[i];
            end else begin
               y -= tx;
               z += lin_tab[i];
            end
         end
      end else if (s.cmd == CMD_HYP_ROT || s.cmd == CMD_HYP_VEC) begin
         for (j = -REXP; j <= NSTAGE - 2; j++) begin
            passes = (j > 0 && (j == 4 || j == 13 || j == 40 || j == 121)) ? 2 : 1;
            for (p = 0; p < passes; p++) begin
               if (vec) up = (x != 0) && (y != 0) && ((x < 0) != (y < 0));
               else up = (z >= 0);
               if (j <= 0) begin
                  tx = x - (x >>> (2 - j));
                  ty = y - (y >>> (2 - j));
               end else begin
                  tx = x >>> j;
                  ty = y >>> j;
               end
               if (up) begin
                  x += ty;
                  y += tx;
                  z -= atanh_tab[j + REXP];
               end else begin
                  x -= ty;
                  y -= tx;
                  z += atanh_tab[j + REXP];
               end
            end
         end
      end
      r.x = DATA_W'(clip24(x, ovf));
      r.y = DATA_W'(clip24(y, ovf));
      r.z = DATA_W'(clip24(z, ovf));
      r.ovf = ovf;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at result %0d: %s got %0d expected %0d", result_count, what, got,
               want);
      error_count++;
   endtask

   task automatic send_item(cordic_in_type s, bit known, cordic_out_type res);
      int gap;
      cordic_out_type pred;
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.cmd     <= s.cmd;
      req_chan.x_start <= s.x;
      req_chan.y_start <= s.y;
      req_chan.z_start <= s.z;
      do @(posedge clock); while (!req_chan.ready);
      pred = cordic_predict(s);
      if (known) begin
         if (pred.x != res.x) report_mismatch("table x", pred.x, res.x);
         if (pred.y != res.y) report_mismatch("table y", pred.y, res.y);
         if (pred.z != res.z) report_mismatch("table z", pred.z, res.z);
         if (pred.ovf != res.ovf) report_mismatch("table overflow", pred.ovf, res.ovf);
      end
      expected_results = {expected_results, pred};
      cmd_hits[s.cmd]++;
      sent_count++;
   endtask

   function automatic cordic_out_type mk(int x, int y, int z, bit o);
      cordic_out_type r;
      r.x = DATA_W'(x);
      r.y = DATA_W'(y);
      r.z = DATA_W'(z);
      r.ovf = o;
      return r;
   endfunction

   function automatic row_type mkrow(logic [2:0] cmd, logic signed [DATA_W-1:0] x,
                                     logic signed [DATA_W-1:0] y,
                                     logic signed [DATA_W-1:0] z, bit known,
                                     cordic_out_type res);
      row_type r;
      r.stim.cmd = cmd;
      r.stim.x = x;
      r.stim.y = y;
      r.stim.z = z;
      r.known = known;
      r.res = res;
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] rnd_val(int sel);
      case (sel)
         0: return DMAX;
         1: return DMIN;
         2: return DATA_W'($urandom_range(0, 1048576));
         3: return -DATA_W'($urandom_range(0, 1048576));
         default: return DATA_W'($urandom);
      endcase
   endfunction

   // Sink side: random stalls, compare against the oldest expectation.
   initial begin
      cordic_out_type want;
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (1) begin
         stall = $urandom_range(0, 11);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && !reset));
         if (expected_results.size() == 0) begin
            $display("unexpected transaction on response channel");
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_chan.x_result !== want.x) report_mismatch("x", rsp_chan.x_result, want.x);
            if (rsp_chan.y_result !== want.y) report_mismatch("y", rsp_chan.y_result, want.y);
            if (rsp_chan.z_result !== want.z) report_mismatch("z", rsp_chan.z_result, want.z);
            if (rsp_chan.overflow !== want.ovf)
               report_mismatch("overflow", rsp_chan.overflow, want.ovf);
         end
         result_count++;
      end
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("FAIL unified_cordic_rotator");
      $finish;
   end

   initial begin
      cordic_in_type s;
      cordic_out_type z0;
      int n, guard, mode;
      error_count = 0;
      result_count = 0;
      sent_count = 0;
      z0 = mk(0, 0, 0, 0);
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.cmd     <= '0;
      req_chan.x_start <= '0;
      req_chan.y_start <= '0;
      req_chan.z_start <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // cmd, x, y, z, known, expected
      rows = {rows, mkrow(3'd6, DMAX, DMIN, 24'sd12345, 1, mk(8388607, -8388608, 12345, 0))};
      rows = {rows, mkrow(3'd7, DMIN, 24'sd0, DMAX, 1, mk(-8388608, 0, 8388607, 0))};
      rows = {rows, mkrow(CMD_CIRC_ROT, 24'sd0, 24'sd0, 24'sd0, 0, z0)};
      rows = {rows, mkrow(CMD_LIN_ROT, 24'sd0, 24'sd0, 24'sd0, 0, z0)};
      rows = {rows, mkrow(CMD_CIRC_ROT, 24'sd636750, 24'sd0, 24'sd1000000, 0, z0)};
      rows = {rows, mkrow(CMD_CIRC_ROT, 24'sd636750, 24'sd0, 24'sd3000000, 0, z0)};
      rows = {rows, mkrow(CMD_CIRC_ROT, 24'sd636750, 24'sd0, 24'sd4000000, 0, z0)};
      rows = {rows, mkrow(CMD_CIRC_ROT, 24'sd636750, 24'sd0, 24'sd4941298, 0, z0)};
      rows = {rows, mkrow(CMD_CIRC_ROT, 24'sd636750, 24'sd0, 24'sd6000000, 0, z0)};
      rows = {rows, mkrow(CMD_CIRC_ROT, DMAX, DMAX, DMIN, 0, z0)};
      rows = {rows, mkrow(CMD_CIRC_VEC, 24'sd1048576, 24'sd1048576, 24'sd0, 0, z0)};
      rows = {rows, mkrow(CMD_CIRC_VEC, -24'sd1048576, 24'sd500000, 24'sd0, 0, z0)};
      rows = {rows, mkrow(CMD_CIRC_VEC, -24'sd1048576, -24'sd500000, 24'sd0, 0, z0)};
      rows = {rows, mkrow(CMD_CIRC_VEC, DMIN, DMIN, DMAX, 0, z0)};
      rows = {rows, mkrow(CMD_LIN_ROT, 24'sd1048576, 24'sd0, 24'sd1500000, 0, z0)};
      rows = {rows, mkrow(CMD_LIN_ROT, DMAX, DMAX, DMAX, 0, z0)};
      rows = {rows, mkrow(CMD_LIN_VEC, 24'sd2097152, 24'sd1048576, 24'sd0, 0, z0)};
      rows = {rows, mkrow(CMD_LIN_VEC, DMIN, DMAX, DMIN, 0, z0)};
      rows = {rows, mkrow(CMD_HYP_ROT, 24'sd1048576, 24'sd0, 24'sd1048576, 0, z0)};
      rows = {rows, mkrow(CMD_HYP_ROT, DMAX, DMIN, DMAX, 0, z0)};
      rows = {rows, mkrow(CMD_HYP_VEC, 24'sd2097152, -24'sd1048576, 24'sd0, 0, z0)};
      rows = {rows, mkrow(CMD_HYP_VEC, 24'sd0, 24'sd1048576, 24'sd0, 0, z0)};
      rows = {rows, mkrow(CMD_HYP_VEC, DMIN, DMIN, DMIN, 0, z0)};
      foreach (rows[k]) send_item(rows[k].stim, rows[k].known, rows[k].res);

      // Drain completely once before the random part.
      req_chan.valid <= 1'b0;
      @(posedge clock);
      guard = 0;
      while (expected_results.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         mode = $urandom_range(0, 9);
         s.cmd = (mode == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
         s.x = rnd_val($urandom_range(0, 7));
         s.y = rnd_val($urandom_range(0, 7));
         s.z = rnd_val($urandom_range(0, 7));
         send_item(s, 0, z0);
         if (n == RANDOM_ITEMS / 2) begin
            // Hold off until everything in flight has come back.
            req_chan.valid <= 1'b0;
            @(posedge clock);
            while (expected_results.size() != 0) @(posedge clock);
         end
      end
      req_chan.valid <= 1'b0;
      @(posedge clock);

      while (expected_results.size() != 0) @(posedge clock);
      repeat (LATENCY_WAIT) @(posedge clock);
      $display("sent %0d transactions, checked %0d results", sent_count, result_count);
      $display("per command: %0d %0d %0d %0d %0d %0d, pass-through %0d", cmd_hits[0],
               cmd_hits[1], cmd_hits[2], cmd_hits[3], cmd_hits[4], cmd_hits[5],
               cmd_hits[6] + cmd_hits[7]);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("PASS unified_cordic_rotator");
      end else begin
         $display("FAIL unified_cordic_rotator");
      end
      $finish;
   end

endmodule
